>>> sv/spl_pkg.sv
// Shared types, constants and the control program of the stereo peak limiter.
// Used by the channel interfaces and by the limiter core; depends on nothing.
package spl_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int GAIN_BITS       = 24;
  localparam int GAIN_FRAC       = 23;
  localparam int DIV_STEPS       = 24;
  localparam int DIV_CNT_BITS    = $clog2(DIV_STEPS);

  localparam logic [GAIN_BITS-1:0] UNITY       = 24'd8388608;
  localparam logic [GAIN_BITS-1:0] THR_RESET   = 24'd8103818;
  localparam logic [GAIN_BITS-1:0] COEFF_RESET = 24'd1747;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ENABLE    = 2'd0;
  localparam cfg_idx_t CFG_THRESHOLD = 2'd1;
  localparam cfg_idx_t CFG_RELEASE   = 2'd2;

  // Input command codes.
  localparam logic CMD_PROCESS    = 1'b0;
  localparam logic CMD_GAIN_RESET = 1'b1;

  // Program steps.
  typedef logic [3:0] step_t;
  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_MODE     = 4'd1;
  localparam step_t STEP_MUL_PEAK = 4'd2;
  localparam step_t STEP_TEST     = 4'd3;
  localparam step_t STEP_DIV      = 4'd4;
  localparam step_t STEP_MUL_REL  = 4'd5;
  localparam step_t STEP_RELEASE  = 4'd6;
  localparam step_t STEP_MUL_L    = 4'd7;
  localparam step_t STEP_HOLD_L   = 4'd8;
  localparam step_t STEP_MUL_R    = 4'd9;
  localparam step_t STEP_EMIT     = 4'd10;
  localparam step_t STEP_PASS     = 4'd11;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_RELEASE,
    OP_HOLD_L,
    OP_EMIT,
    OP_PASS
  } op_t;

  typedef enum logic [1:0] {
    MA_PEAK,
    MA_COEFF,
    MA_LEFT,
    MA_RIGHT
  } mul_a_t;

  typedef enum logic {
    MB_GAIN,
    MB_DIFF
  } mul_b_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_CMD,
    COND_DISABLED,
    COND_ATTACK,
    COND_DIV_MORE
  } cond_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_OUT
  } hold_t;

  typedef struct packed {
    op_t    op;
    mul_a_t a_sel;
    mul_b_t b_sel;
    hold_t  hold;
    cond_t  cond;
    step_t  jmp_step;
    step_t  nxt_step;
  } ucode_t;

  // Control store: one word per step. A step waits on its hold condition,
  // then jumps when its condition is true and falls through otherwise.
  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    w = '{OP_NONE, MA_PEAK, MB_GAIN, HOLD_NONE, COND_NEVER, STEP_IDLE, STEP_IDLE};
    unique case (pc)
      STEP_IDLE:     w = '{OP_LOAD, MA_PEAK, MB_GAIN, HOLD_IN, COND_CMD,
                           STEP_IDLE, STEP_MODE};
      STEP_MODE:     w = '{OP_NONE, MA_PEAK, MB_GAIN, HOLD_NONE, COND_DISABLED,
                           STEP_PASS, STEP_MUL_PEAK};
      STEP_MUL_PEAK: w = '{OP_MUL, MA_PEAK, MB_GAIN, HOLD_NONE, COND_NEVER,
                           STEP_IDLE, STEP_TEST};
      STEP_TEST:     w = '{OP_DIV_INIT, MA_PEAK, MB_GAIN, HOLD_NONE, COND_ATTACK,
                           STEP_DIV, STEP_MUL_REL};
      STEP_DIV:      w = '{OP_DIV_STEP, MA_PEAK, MB_GAIN, HOLD_NONE, COND_DIV_MORE,
                           STEP_DIV, STEP_MUL_L};
      STEP_MUL_REL:  w = '{OP_MUL, MA_COEFF, MB_DIFF, HOLD_NONE, COND_NEVER,
                           STEP_IDLE, STEP_RELEASE};
      STEP_RELEASE:  w = '{OP_RELEASE, MA_PEAK, MB_GAIN, HOLD_NONE, COND_NEVER,
                           STEP_IDLE, STEP_MUL_L};
      STEP_MUL_L:    w = '{OP_MUL, MA_LEFT, MB_GAIN, HOLD_NONE, COND_NEVER,
                           STEP_IDLE, STEP_HOLD_L};
      STEP_HOLD_L:   w = '{OP_HOLD_L, MA_PEAK, MB_GAIN, HOLD_NONE, COND_NEVER,
                           STEP_IDLE, STEP_MUL_R};
      STEP_MUL_R:    w = '{OP_MUL, MA_RIGHT, MB_GAIN, HOLD_NONE, COND_NEVER,
                           STEP_IDLE, STEP_EMIT};
      STEP_EMIT:     w = '{OP_EMIT, MA_PEAK, MB_GAIN, HOLD_OUT, COND_NEVER,
                           STEP_IDLE, STEP_IDLE};
      STEP_PASS:     w = '{OP_PASS, MA_PEAK, MB_GAIN, HOLD_OUT, COND_NEVER,
                           STEP_IDLE, STEP_IDLE};
      default:       w = '{OP_NONE, MA_PEAK, MB_GAIN, HOLD_NONE, COND_NEVER,
                           STEP_IDLE, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> sv/spl_if.sv
// Valid/ready channel interfaces of the stereo peak limiter: sample pairs in,
// limited pairs out. Depends on spl_pkg for the default sample width.
interface spl_in_if #(
  parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;

  modport source (output valid, cmd, sample_left, sample_right, input ready);
  modport sink   (input valid, cmd, sample_left, sample_right, output ready);
endinterface

interface spl_out_if #(
  parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] limited_left;
  logic signed [SAMPLE_BITS-1:0] limited_right;

  modport source (output valid, limited_left, limited_right, input ready);
  modport sink   (input valid, limited_left, limited_right, output ready);
endinterface

>>> sv/stereo_peak_limiter_core.sv
// Linked stereo peak limiter with instant attack, run by a microcoded sequencer.
// Depends on spl_pkg (types, constants, control store) and spl_if (channels).
//
// Usage:
//   in_chan carries a command and a signed stereo pair. Command 0 processes the
//   pair; command 1 sets the gain back to unity and produces no transfer on
//   out_chan. out_chan carries the limited pair, one transfer per processed pair.
//   cfg_we/cfg_index/cfg_data write enable (0), threshold_linear (1) and
//   release_coeff (2); other indexes are ignored. Write only while idle.
// Sequencing:
//   One item at a time, taken only in the idle step. A pass-through pair runs
//   the mode and pass steps; others run mode, peak multiply, test, then release
//   multiply and release, or for an attack the 24-step restoring divider that
//   forms threshold / peak one quotient bit per cycle; then left, right, emit.
//   All multiplies share one multiplier, one product per step.
// Reset and stall:
//   Synchronous active-low reset sets gain to unity, restores the register
//   defaults and empties the output register. A finished result sits in the
//   output register while out_chan is stalled; the next item is accepted and
//   worked on meanwhile, and the sequencer waits at its final step until the
//   output register is free.
module stereo_peak_limiter_core #(
  parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  spl_in_if.sink                        in_chan,
  spl_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  spl_pkg::cfg_idx_t             cfg_index,
  input  logic [spl_pkg::GAIN_BITS-1:0] cfg_data
);

  localparam int GB = spl_pkg::GAIN_BITS;
  localparam int GF = spl_pkg::GAIN_FRAC;
  localparam int MA = (SAMPLE_BITS + 1 > GB + 1) ? SAMPLE_BITS + 1 : GB + 1;
  localparam int MB = GB + 1;
  localparam int PW = MA + MB;
  localparam int DW = GB + SAMPLE_BITS - 1;
  localparam int DCW = spl_pkg::DIV_CNT_BITS;

  localparam logic signed [PW-1:0] SAT_MAX =
    {{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_MIN = ~SAT_MAX;
  localparam logic signed [PW-1:0] RND_HALF =
    {{(PW-GF){1'b0}}, 1'b1, {(GF-1){1'b0}}};

  // Control state.
  spl_pkg::step_t pc_r, pc_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           enable_r;
  logic [GB-1:0]  thr_r, coeff_r;
  logic [GB-1:0]  gain_r, gain_nxt;
  logic [DCW-1:0] div_cnt_r, div_cnt_nxt;

  // Datapath registers.
  logic signed [SAMPLE_BITS-1:0] sl_r, sl_nxt, sr_r, sr_nxt;
  logic [SAMPLE_BITS-1:0]        peak_r, peak_nxt;
  logic signed [PW-1:0]          prod_r, prod_nxt;
  logic [SAMPLE_BITS-1:0]        rem_r, rem_nxt;
  logic [GB-1:0]                 quo_r, quo_nxt;
  logic signed [SAMPLE_BITS-1:0] res_l_r, res_l_nxt;
  logic signed [SAMPLE_BITS-1:0] out_l_r, out_l_nxt, out_r_r, out_r_nxt;

  spl_pkg::ucode_t uw;
  logic            in_fire, out_free, go, cond_true, attack;

  logic [GB-1:0]                 thr_eff, coeff_eff;
  logic [DW-1:0]                 thr_sh;
  logic [SAMPLE_BITS-1:0]        abs_l, abs_r;
  logic signed [MA-1:0]          mul_a;
  logic signed [MB-1:0]          mul_b;
  logic signed [PW-1:0]          mul_p;
  logic [SAMPLE_BITS:0]          trial, trial_sub;
  logic                          q_bit;
  logic [47:0]                   rel_tmp;
  logic [GB:0]                   gain_sum;
  logic signed [PW-1:0]          scaled;
  logic signed [SAMPLE_BITS-1:0] scaled_sat;

  assign uw = spl_pkg::ucode_rom(pc_r);

  assign in_chan.ready      = (uw.hold == spl_pkg::HOLD_IN);
  assign in_fire            = in_chan.valid && in_chan.ready;
  assign out_free           = !out_valid_r || out_chan.ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.limited_left  = out_l_r;
  assign out_chan.limited_right = out_r_r;

  // Registers above unity act as unity.
  assign thr_eff   = (thr_r > spl_pkg::UNITY) ? spl_pkg::UNITY : thr_r;
  assign coeff_eff = (coeff_r > spl_pkg::UNITY) ? spl_pkg::UNITY : coeff_r;
  assign thr_sh    = {thr_eff, {(SAMPLE_BITS-1){1'b0}}};

  assign abs_l = in_chan.sample_left[SAMPLE_BITS-1] ?
                 (~in_chan.sample_left + SAMPLE_BITS'(1)) : in_chan.sample_left;
  assign abs_r = in_chan.sample_right[SAMPLE_BITS-1] ?
                 (~in_chan.sample_right + SAMPLE_BITS'(1)) : in_chan.sample_right;

  // Shared multiplier.
  always_comb begin
    case (uw.a_sel)
      spl_pkg::MA_PEAK:  mul_a = MA'($signed({1'b0, peak_r}));
      spl_pkg::MA_COEFF: mul_a = MA'($signed({1'b0, coeff_eff}));
      spl_pkg::MA_LEFT:  mul_a = MA'(sl_r);
      spl_pkg::MA_RIGHT: mul_a = MA'(sr_r);
      default:           mul_a = MA'($signed({1'b0, peak_r}));
    endcase
    case (uw.b_sel)
      spl_pkg::MB_GAIN: mul_b = $signed({1'b0, gain_r});
      spl_pkg::MB_DIFF: mul_b = $signed({1'b0, spl_pkg::UNITY - gain_r});
      default:          mul_b = $signed({1'b0, gain_r});
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign attack = $unsigned(prod_r) > PW'(thr_sh);

  // Restoring divider step: the remainder stays below the peak, and quo_r
  // shifts out dividend bits while it shifts in quotient bits.
  assign trial     = {rem_r, quo_r[GB-1]};
  assign trial_sub = trial - {1'b0, peak_r};
  assign q_bit     = (trial >= {1'b0, peak_r});

  // Release step rounds up so that the gain can reach unity exactly.
  assign rel_tmp  = prod_r[47:0] + (48'(spl_pkg::UNITY) - 48'd1);
  assign gain_sum = {1'b0, gain_r} + rel_tmp[47:GF];

  assign scaled = (prod_r + RND_HALF) >>> GF;
  always_comb begin
    if (scaled > SAT_MAX) begin
      scaled_sat = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (scaled < SAT_MIN) begin
      scaled_sat = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      scaled_sat = scaled[SAMPLE_BITS-1:0];
    end
  end

  // Sequencer: step counter next value.
  always_comb begin
    case (uw.hold)
      spl_pkg::HOLD_NONE: go = 1'b1;
      spl_pkg::HOLD_IN:   go = in_fire;
      spl_pkg::HOLD_OUT:  go = out_free;
      default:            go = 1'b1;
    endcase
    case (uw.cond)
      spl_pkg::COND_NEVER:    cond_true = 1'b0;
      spl_pkg::COND_CMD:      cond_true = (in_chan.cmd == spl_pkg::CMD_GAIN_RESET);
      spl_pkg::COND_DISABLED: cond_true = !enable_r;
      spl_pkg::COND_ATTACK:   cond_true = attack;
      spl_pkg::COND_DIV_MORE: cond_true = (div_cnt_r != '0);
      default:                cond_true = 1'b0;
    endcase
    if (!go) begin
      pc_nxt = pc_r;
    end else if (cond_true) begin
      pc_nxt = uw.jmp_step;
    end else begin
      pc_nxt = uw.nxt_step;
    end
  end

  // Datapath actions decoded from the control word.
  always_comb begin
    gain_nxt      = gain_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    sl_nxt        = sl_r;
    sr_nxt        = sr_r;
    peak_nxt      = peak_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    res_l_nxt     = res_l_r;
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;
    unique case (uw.op)
      spl_pkg::OP_NONE: begin
      end
      spl_pkg::OP_LOAD: begin
        if (in_fire) begin
          if (in_chan.cmd == spl_pkg::CMD_GAIN_RESET) begin
            gain_nxt = spl_pkg::UNITY;
          end else begin
            sl_nxt   = in_chan.sample_left;
            sr_nxt   = in_chan.sample_right;
            peak_nxt = (abs_l > abs_r) ? abs_l : abs_r;
          end
        end
      end
      spl_pkg::OP_MUL: begin
        prod_nxt = mul_p;
      end
      spl_pkg::OP_DIV_INIT: begin
        rem_nxt     = SAMPLE_BITS'(thr_sh[DW-1:GB]);
        quo_nxt     = thr_sh[GB-1:0];
        div_cnt_nxt = DCW'(spl_pkg::DIV_STEPS - 1);
      end
      spl_pkg::OP_DIV_STEP: begin
        rem_nxt     = q_bit ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
        quo_nxt     = {quo_r[GB-2:0], q_bit};
        div_cnt_nxt = div_cnt_r - DCW'(1);
        if (div_cnt_r == '0) begin
          gain_nxt = {quo_r[GB-2:0], q_bit};
        end
      end
      spl_pkg::OP_RELEASE: begin
        gain_nxt = (gain_sum > {1'b0, spl_pkg::UNITY}) ? spl_pkg::UNITY : gain_sum[GB-1:0];
      end
      spl_pkg::OP_HOLD_L: begin
        res_l_nxt = scaled_sat;
      end
      spl_pkg::OP_EMIT: begin
        if (out_free) begin
          out_l_nxt     = res_l_r;
          out_r_nxt     = scaled_sat;
          out_valid_nxt = 1'b1;
        end
      end
      spl_pkg::OP_PASS: begin
        if (out_free) begin
          out_l_nxt     = sl_r;
          out_r_nxt     = sr_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= spl_pkg::STEP_IDLE;
      out_valid_r <= 1'b0;
      gain_r      <= spl_pkg::UNITY;
      div_cnt_r   <= '0;
      enable_r    <= 1'b1;
      thr_r       <= spl_pkg::THR_RESET;
      coeff_r     <= spl_pkg::COEFF_RESET;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      gain_r      <= gain_nxt;
      div_cnt_r   <= div_cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          spl_pkg::CFG_ENABLE:    enable_r <= cfg_data[0];
          spl_pkg::CFG_THRESHOLD: thr_r    <= cfg_data;
          spl_pkg::CFG_RELEASE:   coeff_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sl_r    <= sl_nxt;
    sr_r    <= sr_nxt;
    peak_r  <= peak_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    res_l_r <= res_l_nxt;
    out_l_r <= out_l_nxt;
    out_r_r <= out_r_nxt;
  end

  // The gain never rises above unity.
  a_gain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= spl_pkg::UNITY)
    else $error("gain above unity");

  // Input transfers happen only in the idle step.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> pc_r == spl_pkg::STEP_IDLE)
    else $error("input transfer outside idle step");

  // A new result appears only from the emit or pass-through step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      ($past(pc_r) == spl_pkg::STEP_EMIT || $past(pc_r) == spl_pkg::STEP_PASS))
    else $error("result without emit step");

  // An attack always lowers the gain.
  a_attack_lowers: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == spl_pkg::STEP_DIV && div_cnt_r == '0) |=> gain_r < $past(gain_r))
    else $error("attack did not lower gain");

endmodule
